### sv/snf_pkg.sv
// snf_pkg: shared widths, register indexes, hash and mix constants and
// saturation limits for the 3D simplex noise pipeline. No dependencies.
`default_nettype none

package snf_pkg;

  localparam int COORD_W   = 32;
  localparam int NOISE_W   = 22;
  localparam int REG_IDX_W = 2;

  // configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_OFFSET_X = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_OFFSET_Y = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_OFFSET_Z = 2'd2;

  // bit-noise hash constants
  localparam logic [31:0] HASH_MUL1 = 32'h85297A4D;
  localparam logic [31:0] HASH_ADD  = 32'h68E31DA4;
  localparam logic [31:0] HASH_MUL2 = 32'h1B56C4E9;

  // gradient mix constants, one row per gradient component
  localparam logic [31:0] MIX0_Y = 32'h651A6BE3;
  localparam logic [31:0] MIX0_Z = 32'h218A6147;
  localparam logic [31:0] MIX0_K = 32'h118A5191;
  localparam logic [31:0] MIX1_Y = 32'h118A5191;
  localparam logic [31:0] MIX1_Z = 32'h218AE247;
  localparam logic [31:0] MIX1_K = 32'h2B8AE147;
  localparam logic [31:0] MIX2_Y = 32'h21613122;
  localparam logic [31:0] MIX2_Z = 32'h118A5191;
  localparam logic [31:0] MIX2_K = 32'h218AE247;

  // output saturation limits
  localparam logic signed [NOISE_W-1:0] NOISE_MAX = 22'sh1FFFFF;
  localparam logic signed [NOISE_W-1:0] NOISE_MIN = 22'sh200000;

endpackage

`default_nettype wire

### sv/snf_if.sv
// snf_if: valid/ready channel interfaces for sample points and noise values.
// Depends on snf_pkg for field widths.
`default_nettype none

interface snf_point_if;
  import snf_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] coord_x;
  logic signed [COORD_W-1:0] coord_y;
  logic signed [COORD_W-1:0] coord_z;
  modport source (output valid, output coord_x, output coord_y, output coord_z, input ready);
  modport sink   (input valid, input coord_x, input coord_y, input coord_z, output ready);
endinterface

interface snf_noise_if;
  import snf_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [NOISE_W-1:0] noise_value;
  modport source (output valid, output noise_value, input ready);
  modport sink   (input valid, input noise_value, output ready);
endinterface

`default_nettype wire

### sv/simplex_noise_3d_fixed.sv
// simplex_noise_3d_fixed: 18-stage pipeline, one point accepted per cycle.
// The result of S18 is scaled, saturated and held in the output register behind noise valid.
// Throughput: 1 transaction per cycle; the pipeline stalls only when both the
// output register and the skid register hold results.
// Reset (rst, synchronous): clears all valid bits and the offsets to zero.
// Depends on snf_pkg and snf_if.
`default_nettype none

module simplex_noise_3d_fixed #(
  parameter int FRAC_BITS = 16
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              wr_en,
  input  wire [snf_pkg::REG_IDX_W-1:0]     wr_index,
  input  wire [snf_pkg::COORD_W-1:0]       wr_data,
  snf_point_if.sink                        point,
  snf_noise_if.source                      noise
);
  import snf_pkg::*;

  localparam int F    = FRAC_BITS;
  localparam int PW   = 33;            // point plus offset
  localparam int VW   = 36;            // 3p + sum
  localparam int N3   = 35 - F;        // magnitude bits for cell division
  localparam int CW   = 36 - F;        // cell index width
  localparam int GW   = F + 5;         // corner offset (6*d)
  localparam int SQ1W = 2 * F + 7;     // one square
  localparam int SQW  = 2 * F + 9;     // sum of squares
  localparam int NUMW = 2 * F + 13;    // 108*one^2 - 5*sq
  localparam int SH   = 2 * F - 30;
  localparam int SHR  = (SH > 0) ? SH : 0;
  localparam int SHL  = (SH < 0) ? -SH : 0;
  localparam int YWW  = SQ1W + SHL;
  localparam int ZW   = 35;            // num scaled to Q.30 over 4
  localparam int ZLW  = 18;
  localparam int ZHW  = ZW - ZLW;
  localparam int NWW  = 24;            // low-chunk dividend width
  localparam int TW   = 30;
  localparam int DOTW = F + 16;
  localparam int DSHL = (F < 13) ? 13 - F : 0;
  localparam int DSHR = (F > 13) ? F - 13 : 0;
  localparam int DEW  = DOTW + DSHL;
  localparam int DW   = 29;
  localparam int ND   = DW - 1;
  localparam int PRW  = 60;
  localparam int RSH  = 49 - F;

  localparam logic [N3-1:0]  M3 = N3'((64'd1 << N3) / 64'd3);
  localparam logic [ZHW-1:0] MH = ZHW'((64'd1 << ZHW) / 64'd45);
  localparam logic [NWW-1:0] MW = NWW'((64'd1 << NWW) / 64'd45);
  localparam logic [ND-1:0]  MD = ND'((64'd1 << ND) / 64'd3);
  localparam logic signed [GW-1:0]   SIX_ONE = GW'(6 << F);
  localparam logic signed [NUMW-1:0] NUM_TOP = NUMW'(108) <<< (2 * F);
  localparam logic signed [PRW-1:0]  SAT_HI  = PRW'(NOISE_MAX);
  localparam logic signed [PRW-1:0]  SAT_LO  = PRW'(NOISE_MIN);

  // offset registers
  logic signed [COORD_W-1:0] off [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      off[0] <= '0;
      off[1] <= '0;
      off[2] <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_OFFSET_X: off[0] <= wr_data;
        REG_OFFSET_Y: off[1] <= wr_data;
        REG_OFFSET_Z: off[2] <= wr_data;
        default: ;
      endcase
    end
  end

  // pipeline enable and valid bits
  logic        en;
  logic        sk_valid;
  logic        o_valid;
  logic [18:1] v;

  assign en          = !sk_valid;
  assign point.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[17:1], point.valid};
    end
  end

  // S1: add offset
  logic signed [PW-1:0] s1_p [3];
  always_ff @(posedge clk) begin
    if (en) begin
      s1_p[0] <= PW'(point.coord_x) + PW'(off[0]);
      s1_p[1] <= PW'(point.coord_y) + PW'(off[1]);
      s1_p[2] <= PW'(point.coord_z) + PW'(off[2]);
    end
  end

  // S2: skew, floor by one, split sign for the divide by 3
  logic [N3-1:0]        s2_x   [3];
  logic                 s2_neg [3];
  logic signed [GW-1:0] s2_plo [3];
  always_ff @(posedge clk) begin
    logic signed [VW-1:0] sum;
    logic signed [VW-1:0] vv;
    logic signed [VW-1:0] w;
    if (en) begin
      sum = VW'(s1_p[0]) + VW'(s1_p[1]) + VW'(s1_p[2]);
      for (int i = 0; i < 3; i++) begin
        vv = (VW'(s1_p[i]) <<< 1) + VW'(s1_p[i]) + sum;
        w  = vv >>> F;
        s2_neg[i] <= w[VW-1];
        s2_x[i]   <= w[VW-1] ? N3'(~w) : N3'(w);
        s2_plo[i] <= GW'(s1_p[i]);
      end
    end
  end

  // S3: reciprocal multiply for /3
  logic [N3-1:0]        s3_q0  [3];
  logic [N3-1:0]        s3_x   [3];
  logic                 s3_neg [3];
  logic signed [GW-1:0] s3_plo [3];
  always_ff @(posedge clk) begin
    logic [2*N3-1:0] pr;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pr = (2*N3)'(s2_x[i]) * (2*N3)'(M3);
        s3_q0[i]  <= N3'(pr >> N3);
        s3_x[i]   <= s2_x[i];
        s3_neg[i] <= s2_neg[i];
        s3_plo[i] <= s2_plo[i];
      end
    end
  end

  // S4: quotient correction, restore sign -> cell index
  logic signed [CW-1:0] s4_cell [3];
  logic signed [GW-1:0] s4_plo  [3];
  always_ff @(posedge clk) begin
    logic [N3-1:0] r;
    logic [N3-1:0] q;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        r = s3_x[i] - ((s3_q0[i] << 1) + s3_q0[i]);
        q = (r >= N3'(3)) ? s3_q0[i] + N3'(1) : s3_q0[i];
        s4_cell[i] <= s3_neg[i] ? ~{1'b0, q} : {1'b0, q};
        s4_plo[i]  <= s3_plo[i];
      end
    end
  end

  // S5: first corner offset, kept modulo 2^GW (true value fits)
  logic signed [GW-1:0] s5_g0   [3];
  logic signed [CW-1:0] s5_cell [3];
  always_ff @(posedge clk) begin
    logic signed [GW-1:0] cs;
    logic signed [GW-1:0] ct;
    if (en) begin
      cs = GW'(s4_cell[0]) + GW'(s4_cell[1]) + GW'(s4_cell[2]);
      for (int i = 0; i < 3; i++) begin
        ct = GW'(s4_cell[i]) <<< F;
        s5_g0[i]   <= (s4_plo[i] <<< 2) + (s4_plo[i] <<< 1)
                      - (ct <<< 2) - (ct <<< 1) + (cs <<< F);
        s5_cell[i] <= s4_cell[i];
      end
    end
  end

  // S6: rank offsets -> middle corners (bit0 x, bit1 y, bit2 z)
  logic [2:0]           s6_o1, s6_o2;
  logic signed [GW-1:0] s6_g0   [3];
  logic signed [CW-1:0] s6_cell [3];
  always_ff @(posedge clk) begin
    if (en) begin
      if (s5_g0[0] >= s5_g0[1]) begin
        if (s5_g0[1] >= s5_g0[2]) begin
          s6_o1 <= 3'b001; s6_o2 <= 3'b011;
        end else if (s5_g0[0] >= s5_g0[2]) begin
          s6_o1 <= 3'b001; s6_o2 <= 3'b101;
        end else begin
          s6_o1 <= 3'b100; s6_o2 <= 3'b101;
        end
      end else begin
        if (s5_g0[1] < s5_g0[2]) begin
          s6_o1 <= 3'b100; s6_o2 <= 3'b110;
        end else if (s5_g0[0] < s5_g0[2]) begin
          s6_o1 <= 3'b010; s6_o2 <= 3'b110;
        end else begin
          s6_o1 <= 3'b010; s6_o2 <= 3'b011;
        end
      end
      s6_g0   <= s5_g0;
      s6_cell <= s5_cell;
    end
  end

  // S7: per-corner offsets and hash mix words
  logic signed [GW-1:0] s7_g   [4][3];
  logic [31:0]          s7_mix [4][3];
  always_ff @(posedge clk) begin
    logic [2:0]  ok;
    logic [31:0] c [3];
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        case (k)
          0:       ok = 3'b000;
          1:       ok = s6_o1;
          2:       ok = s6_o2;
          default: ok = 3'b111;
        endcase
        for (int i = 0; i < 3; i++) begin
          s7_g[k][i] <= s6_g0[i] - (ok[i] ? SIX_ONE : GW'(0)) + (GW'(k) <<< F);
          c[i] = 32'(s6_cell[i]) + 32'(ok[i]);
        end
        s7_mix[k][0] <= c[0] ^ (MIX0_Y + c[1]) ^ (MIX0_Z - c[2]) ^ MIX0_K;
        s7_mix[k][1] <= c[0] ^ (MIX1_Y - c[1]) ^ (MIX1_Z + c[2]) ^ MIX1_K;
        s7_mix[k][2] <= c[0] ^ (MIX2_Y - c[1]) ^ (MIX2_Z - c[2]) ^ MIX2_K;
      end
    end
  end

  // S8: squares, first hash multiply
  logic [SQ1W-1:0]      s8_sq [4][3];
  logic [31:0]          s8_m  [4][3];
  logic signed [GW-1:0] s8_g  [4][3];
  always_ff @(posedge clk) begin
    logic signed [2*GW-1:0] sqf;
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        for (int i = 0; i < 3; i++) begin
          sqf = s7_g[k][i] * s7_g[k][i];
          s8_sq[k][i] <= SQ1W'(sqf);
          s8_m[k][i]  <= s7_mix[k][i] * HASH_MUL1;
        end
      end
      s8_g <= s7_g;
    end
  end

  // S9: falloff numerator scaled to Q.30/4, hash shift-add-shift
  logic [ZW-1:0]        s9_z   [4];
  logic                 s9_pos [4];
  logic [31:0]          s9_m   [4][3];
  logic signed [GW-1:0] s9_g   [4][3];
  always_ff @(posedge clk) begin
    logic [SQW-1:0]         sqs;
    logic signed [NUMW-1:0] num;
    logic [YWW-1:0]         yw;
    logic [ZW+1:0]          y;
    logic [31:0]            a, b;
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        sqs = SQW'(s8_sq[k][0]) + SQW'(s8_sq[k][1]) + SQW'(s8_sq[k][2]);
        num = NUM_TOP - NUMW'(sqs) - (NUMW'(sqs) <<< 2);
        yw  = YWW'(num[SQ1W-1:0]) << SHL;
        y   = (ZW+2)'(yw >> SHR);
        s9_z[k]   <= y[ZW+1:2];
        s9_pos[k] <= (num > NUMW'(0));
        for (int i = 0; i < 3; i++) begin
          a = s8_m[k][i] ^ (s8_m[k][i] >> 8);
          b = a + HASH_ADD;
          s9_m[k][i] <= b ^ (b << 8);
        end
      end
      s9_g <= s8_g;
    end
  end

  // S10: /45 of high chunk (multiply), second hash multiply
  logic [ZHW-1:0]       s10_q0  [4];
  logic [ZW-1:0]        s10_z   [4];
  logic                 s10_pos [4];
  logic [31:0]          s10_m   [4][3];
  logic signed [GW-1:0] s10_g   [4][3];
  always_ff @(posedge clk) begin
    logic [2*ZHW-1:0] pr;
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        pr = (2*ZHW)'(s9_z[k][ZW-1:ZLW]) * (2*ZHW)'(MH);
        s10_q0[k] <= ZHW'(pr >> ZHW);
        for (int i = 0; i < 3; i++) s10_m[k][i] <= s9_m[k][i] * HASH_MUL2;
      end
      s10_z   <= s9_z;
      s10_pos <= s9_pos;
      s10_g   <= s9_g;
    end
  end

  // S11: high chunk correction, final hash fold
  logic [ZHW-1:0]       s11_qh  [4];
  logic [NWW-1:0]       s11_w   [4];
  logic                 s11_pos [4];
  logic [9:0]           s11_h   [4][3];
  logic signed [GW-1:0] s11_g   [4][3];
  always_ff @(posedge clk) begin
    logic [ZHW-1:0] r;
    logic [ZHW-1:0] q;
    logic [31:0]    d;
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        r = s10_z[k][ZW-1:ZLW] - ZHW'(s10_q0[k] * ZHW'(45));
        q = (r >= ZHW'(45)) ? s10_q0[k] + ZHW'(1) : s10_q0[k];
        if (r >= ZHW'(45)) r = r - ZHW'(45);
        s11_qh[k] <= q;
        s11_w[k]  <= {r[NWW-ZLW-1:0], s10_z[k][ZLW-1:0]};
        for (int i = 0; i < 3; i++) begin
          d = s10_m[k][i] ^ (s10_m[k][i] >> 8);
          s11_h[k][i] <= d[9:0];
        end
      end
      s11_pos <= s10_pos;
      s11_g   <= s10_g;
    end
  end

  // S12: /45 of low chunk (multiply), gradient dot product
  logic [ZHW-1:0]         s12_qh  [4];
  logic [NWW-1:0]         s12_w   [4];
  logic [NWW-1:0]         s12_q0  [4];
  logic                   s12_pos [4];
  logic signed [DOTW-1:0] s12_dot [4];
  always_ff @(posedge clk) begin
    logic [2*NWW-1:0]       pr;
    logic signed [DOTW-1:0] acc;
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        pr = (2*NWW)'(s11_w[k]) * (2*NWW)'(MW);
        s12_q0[k] <= NWW'(pr >> NWW);
        acc = '0;
        for (int i = 0; i < 3; i++)
          acc = acc + DOTW'($signed({1'b0, s11_h[k][i]}) * s11_g[k][i]);
        s12_dot[k] <= acc;
      end
      s12_qh  <= s11_qh;
      s12_w   <= s11_w;
      s12_pos <= s11_pos;
    end
  end

  // S13: assemble t, scale dot and split sign for the divide by 3
  logic [TW-1:0] s13_t   [4];
  logic [ND-1:0] s13_xd  [4];
  logic          s13_neg [4];
  always_ff @(posedge clk) begin
    logic [NWW-1:0]        r;
    logic [NWW-1:0]        q;
    logic signed [DEW-1:0] de;
    logic signed [DW-1:0]  dd;
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        r = s12_w[k] - NWW'(s12_q0[k] * NWW'(45));
        q = (r >= NWW'(45)) ? s12_q0[k] + NWW'(1) : s12_q0[k];
        s13_t[k] <= s12_pos[k] ? (TW'(s12_qh[k]) << ZLW) + TW'(q) : TW'(0);
        de = DEW'(s12_dot[k]);
        dd = DW'((de <<< DSHL) >>> DSHR);
        s13_neg[k] <= dd[DW-1];
        s13_xd[k]  <= dd[DW-1] ? ND'(~dd) : ND'(dd);
      end
    end
  end

  // S14: t^2, reciprocal multiply for /3
  logic [TW-1:0] s14_t2  [4];
  logic [ND-1:0] s14_q0  [4];
  logic [ND-1:0] s14_xd  [4];
  logic          s14_neg [4];
  always_ff @(posedge clk) begin
    logic [2*TW-1:0] tt;
    logic [2*ND-1:0] pr;
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        tt = (2*TW)'(s13_t[k]) * (2*TW)'(s13_t[k]);
        s14_t2[k] <= TW'(tt >> 30);
        pr = (2*ND)'(s13_xd[k]) * (2*ND)'(MD);
        s14_q0[k] <= ND'(pr >> ND);
      end
      s14_xd  <= s13_xd;
      s14_neg <= s13_neg;
    end
  end

  // S15: t^4, quotient correction -> scaled dot
  logic [TW-1:0]        s15_t4 [4];
  logic signed [DW-1:0] s15_dq [4];
  always_ff @(posedge clk) begin
    logic [2*TW-1:0] tt;
    logic [ND-1:0]   r;
    logic [ND-1:0]   q;
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        tt = (2*TW)'(s14_t2[k]) * (2*TW)'(s14_t2[k]);
        s15_t4[k] <= TW'(tt >> 30);
        r = s14_xd[k] - ((s14_q0[k] << 1) + s14_q0[k]);
        q = (r >= ND'(3)) ? s14_q0[k] + ND'(1) : s14_q0[k];
        s15_dq[k] <= s14_neg[k] ? ~{1'b0, q} : {1'b0, q};
      end
    end
  end

  // S16: corner contribution
  logic signed [PRW-1:0] s16_pr [4];
  always_ff @(posedge clk) begin
    logic signed [TW:0] ts;
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        ts = $signed({1'b0, s15_t4[k]});
        s16_pr[k] <= PRW'(ts * s15_dq[k]);
      end
    end
  end

  // S17, S18: corner sum
  logic signed [PRW-1:0] s17_a, s17_b, s18_acc;
  always_ff @(posedge clk) begin
    if (en) begin
      s17_a   <= s16_pr[0] + s16_pr[1];
      s17_b   <= s16_pr[2] + s16_pr[3];
      s18_acc <= s17_a + s17_b;
    end
  end

  // scale and saturate
  logic signed [PRW-1:0]     res_full;
  logic signed [NOISE_W-1:0] res;
  always_comb begin
    res_full = s18_acc >>> RSH;
    if (res_full > SAT_HI)      res = NOISE_MAX;
    else if (res_full < SAT_LO) res = NOISE_MIN;
    else                        res = NOISE_W'(res_full);
  end

  // output register with skid register
  logic signed [NOISE_W-1:0] o_data, sk_data;
  logic                      take_o;

  assign take_o = !o_valid || noise.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid  <= 1'b0;
      sk_valid <= 1'b0;
    end else if (en) begin
      if (v[18]) begin
        if (take_o) o_valid <= 1'b1;
        else        sk_valid <= 1'b1;
      end else if (noise.ready) begin
        o_valid <= 1'b0;
      end
    end else if (noise.ready) begin
      sk_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (v[18]) begin
        if (take_o) o_data <= res;
        else        sk_data <= res;
      end
    end else if (noise.ready) begin
      o_data <= sk_data;
    end
  end

  assign noise.valid       = o_valid;
  assign noise.noise_value = o_data;

endmodule

`default_nettype wire

### sv/snf_checker.sv
// snf_checker: port-level assertions for simplex_noise_3d_fixed, bound below.
// Depends on snf_pkg.
`default_nettype none

module snf_checker (
  input wire                           clk,
  input wire                           rst,
  input wire                           in_ready,
  input wire                           out_valid,
  input wire                           out_ready,
  input wire [snf_pkg::NOISE_W-1:0]    out_value
);
  import snf_pkg::*;

  // a pending result holds until its transaction completes
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("noise valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_value))
    else $error("noise value changed while stalled");

  // input back-pressure only with a result waiting at the output
  a_bp_needs_out: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with empty output");

  // reset empties the pipeline and the output side
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("output or stall not cleared by reset");

endmodule

bind simplex_noise_3d_fixed snf_checker u_snf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (point.ready),
  .out_valid (noise.valid),
  .out_ready (noise.ready),
  .out_value (noise.noise_value)
);

`default_nettype wire
